// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the RTL region back end.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check prop at every clock edge outside reset.
`define TRC_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check prop at every clock edge, reset included.
`define TRC_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/core/trc_pkg.sv =====
// ----------------------------------------------------------------------------
// Trace region counter tracker package
// Shared widths, register indexes, group record type and defaults.
// ----------------------------------------------------------------------------
package trc_pkg;

  localparam int SLOTS            = 4;
  localparam int NUM_COUNTERS_DEF = 4;
  localparam int TABLE_DEPTH_DEF  = 64;
  localparam int QUEUE_DEPTH      = 2;
  localparam int CFG_IDX_W        = 8;

  localparam logic [31:0] CTR_TYPE_LO = 32'd42000000;
  localparam logic [31:0] CTR_TYPE_HI = 32'd42999999;
  localparam logic [15:0] PHASE_MAX   = 16'hFFFF;

  localparam logic [CFG_IDX_W-1:0] REG_SEPARATOR_TYPE = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WATCHED_OBJECT = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PHASE_TYPE_A   = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PHASE_TYPE_B   = 8'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COUNTER_ID_0   = 8'd4;
  localparam logic [CFG_IDX_W-1:0] REG_COUNTER_ID_1   = 8'd5;
  localparam logic [CFG_IDX_W-1:0] REG_COUNTER_ID_2   = 8'd6;
  localparam logic [CFG_IDX_W-1:0] REG_COUNTER_ID_3   = 8'd7;

  typedef struct packed {
    logic                        sep_seen;
    logic [63:0]                 sep_value;
    logic                        phase_seen;
    logic [63:0]                 ts;
    logic [SLOTS-1:0][63:0]      deltas;
  } grp_rec_t;

endpackage

// ===== rtl/core/trc_evt_if.sv =====
// ----------------------------------------------------------------------------
// Trace event channel
// One trace event per transaction.
// ----------------------------------------------------------------------------
interface trc_evt_if;
  logic        valid;
  logic        ready;
  logic [15:0] task_num;
  logic [15:0] thread_num;
  logic [63:0] time_stamp;
  logic [31:0] event_type;
  logic [63:0] event_value;
  logic        last_in_group;

  modport source (output valid, task_num, thread_num, time_stamp, event_type,
                  event_value, last_in_group, input ready);
  modport sink (input valid, task_num, thread_num, time_stamp, event_type,
                event_value, last_in_group, output ready);
endinterface

// ===== rtl/core/trc_res_if.sv =====
// ----------------------------------------------------------------------------
// Region result channel
// One closed region per transaction.
// ----------------------------------------------------------------------------
interface trc_res_if;
  logic        valid;
  logic        ready;
  logic [63:0] region_value;
  logic [15:0] region_phase;
  logic [63:0] start_time;
  logic [63:0] end_time;
  logic [63:0] count_0;
  logic [63:0] count_1;
  logic [63:0] count_2;
  logic [63:0] count_3;
  logic        table_full;

  modport source (output valid, region_value, region_phase, start_time, end_time,
                  count_0, count_1, count_2, count_3, table_full, input ready);
  modport sink (input valid, region_value, region_phase, start_time, end_time,
                count_0, count_1, count_2, count_3, table_full, output ready);
endinterface

// ===== rtl/core/trc_cfg_if.sv =====
// ----------------------------------------------------------------------------
// Configuration write channel
// One register write per transaction.
// ----------------------------------------------------------------------------
interface trc_cfg_if;
  import trc_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [31:0]          data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/core/trace_region_counter_tracker_top.sv =====
// ----------------------------------------------------------------------------
// Trace region counter tracker
// Tracks trace regions and their counter sums, emitting each new closed region.
// ----------------------------------------------------------------------------
// Usage:
//   evt: trace events, one per transaction; last_in_group ends a group.
//   cfg: register writes (index 0..7); always ready, write only while idle.
//   res: closed regions, at most one per group, from an output register.
// A group end goes through a two-entry queue to the back end, which
// applies the group, and on a close walks the seen table: for each
// recorded entry a memory read and a compare, then a final check, an
// emit and a finish step.
// A pair found in the table ends the walk early and skips the emit.
// The front end keeps taking events while the queue has room; the back end
// holds in emit while the result register is full and res.ready is low,
// and the queue then fills.
// Reset clears all control state and the seen-table fill count; the table
// itself needs no clearing pass.
// ----------------------------------------------------------------------------
module trace_region_counter_tracker_top #(
  parameter int NUM_COUNTERS = trc_pkg::NUM_COUNTERS_DEF,
  parameter int TABLE_DEPTH  = trc_pkg::TABLE_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst,
  trc_evt_if.sink   evt,
  trc_cfg_if.sink   cfg,
  trc_res_if.source res
);
  import trc_pkg::*;

  logic     push_valid;
  logic     push_ready;
  grp_rec_t push_data;
  logic     pop_valid;
  logic     pop_ready;
  grp_rec_t pop_data;

  trc_front #(.NUM_COUNTERS(NUM_COUNTERS)) u_front (
    .clk        (clk),
    .rst        (rst),
    .evt        (evt),
    .cfg        (cfg),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  trc_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  trc_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
    .clk        (clk),
    .rst        (rst),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data),
    .res        (res)
  );

endmodule

// ===== rtl/core/trc_fifo.sv =====
// ----------------------------------------------------------------------------
// Group record queue
// Short FIFO between the event front end and the region back end.
// ----------------------------------------------------------------------------
module trc_fifo (
  input  logic              clk,
  input  logic              rst,
  input  logic              push_valid,
  output logic              push_ready,
  input  trc_pkg::grp_rec_t push_data,
  output logic              pop_valid,
  input  logic              pop_ready,
  output trc_pkg::grp_rec_t pop_data
);
  import trc_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  grp_rec_t        entries [QUEUE_DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CW-1:0]   count;
  logic            do_push;
  logic            do_pop;

  assign push_ready = (count != CW'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/core/trc_front.sv =====
// ----------------------------------------------------------------------------
// Event front end
// Holds configuration, filters and classifies events, builds group records.
// ----------------------------------------------------------------------------
module trc_front #(
  parameter int NUM_COUNTERS = trc_pkg::NUM_COUNTERS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  trc_evt_if.sink           evt,
  trc_cfg_if.sink           cfg,
  output logic              push_valid,
  input  logic              push_ready,
  output trc_pkg::grp_rec_t push_data
);
  import trc_pkg::*;

  logic [31:0]            separator_type;
  logic [31:0]            watched_object;
  logic [31:0]            phase_type_a;
  logic [31:0]            phase_type_b;
  logic [SLOTS-1:0][31:0] counter_id;

  logic [SLOTS-1:0][63:0] deltas;
  logic                   sep_seen;
  logic [63:0]            sep_value;
  logic                   phase_seen;

  logic                   accept;
  logic                   match_obj;
  logic                   is_sep;
  logic                   is_phase;
  logic                   is_ctr;
  logic [SLOTS-1:0]       hit;
  grp_rec_t               rec_next;

  assign cfg.ready = 1'b1;
  assign evt.ready = push_ready;
  assign accept    = evt.valid && evt.ready;

  assign match_obj = (evt.task_num == watched_object[31:16]) &&
                     (evt.thread_num == watched_object[15:0]);
  assign is_sep    = (evt.event_type == separator_type);
  assign is_phase  = ((phase_type_a != '0) && (evt.event_type == phase_type_a)) ||
                     ((phase_type_b != '0) && (evt.event_type == phase_type_b));
  assign is_ctr    = (evt.event_type >= CTR_TYPE_LO) && (evt.event_type <= CTR_TYPE_HI);

  always_comb begin
    logic found;
    found = 1'b0;
    hit   = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (i < NUM_COUNTERS && !found && is_ctr && counter_id[i] != '0 &&
          counter_id[i] == evt.event_type) begin
        hit[i] = 1'b1;
        found  = 1'b1;
      end
    end
  end

  always_comb begin
    rec_next.sep_seen   = sep_seen || is_sep;
    rec_next.sep_value  = is_sep ? evt.event_value : sep_value;
    rec_next.phase_seen = phase_seen || is_phase;
    rec_next.ts         = evt.time_stamp;
    for (int i = 0; i < SLOTS; i++) begin
      rec_next.deltas[i] = deltas[i] + (hit[i] ? evt.event_value : 64'd0);
    end
  end

  assign push_valid = evt.valid && match_obj && evt.last_in_group;
  assign push_data  = rec_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      separator_type <= '0;
      watched_object <= '0;
      phase_type_a   <= '0;
      phase_type_b   <= '0;
      counter_id     <= '0;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        REG_SEPARATOR_TYPE: separator_type <= cfg.data;
        REG_WATCHED_OBJECT: watched_object <= cfg.data;
        REG_PHASE_TYPE_A:   phase_type_a   <= cfg.data;
        REG_PHASE_TYPE_B:   phase_type_b   <= cfg.data;
        REG_COUNTER_ID_0:   counter_id[0]  <= cfg.data;
        REG_COUNTER_ID_1:   counter_id[1]  <= cfg.data;
        REG_COUNTER_ID_2:   counter_id[2]  <= cfg.data;
        REG_COUNTER_ID_3:   counter_id[3]  <= cfg.data;
        default: ;
      endcase
    end
  end

  // Clear group state at each group end of the watched object, otherwise accumulate its events.
  always_ff @(posedge clk) begin
    if (rst) begin
      deltas     <= '0;
      sep_seen   <= 1'b0;
      sep_value  <= '0;
      phase_seen <= 1'b0;
    end else if (accept && match_obj) begin
      if (evt.last_in_group) begin
        deltas     <= '0;
        sep_seen   <= 1'b0;
        sep_value  <= '0;
        phase_seen <= 1'b0;
      end else begin
        deltas     <= rec_next.deltas;
        sep_seen   <= rec_next.sep_seen;
        sep_value  <= rec_next.sep_value;
        phase_seen <= rec_next.phase_seen;
      end
    end
  end

endmodule

// ===== rtl/core/trc_back.sv =====
// ----------------------------------------------------------------------------
// Region back end
// Applies group records to the open region, searches the seen table, emits.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module trc_back #(
  parameter int TABLE_DEPTH = trc_pkg::TABLE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              pop_valid,
  output logic              pop_ready,
  input  trc_pkg::grp_rec_t pop_data,
  trc_res_if.source         res
);
  import trc_pkg::*;

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SEARCH = 3'd1;
  localparam logic [2:0] S_CMP    = 3'd2;
  localparam logic [2:0] S_EMIT   = 3'd3;
  localparam logic [2:0] S_FIN    = 3'd4;

  logic [2:0]             state;
  logic                   region_open;
  logic [63:0]            open_value;
  logic [15:0]            open_phase;
  logic [63:0]            open_start;
  logic [SLOTS-1:0][63:0] sums;
  logic [CW-1:0]          seen_count;
  logic [CW-1:0]          idx;
  logic                   cl_sep0;
  logic [63:0]            cl_ts;

  logic [79:0]            seen_mem [TABLE_DEPTH];
  logic [79:0]            rd_data;

  logic                   out_valid;
  logic [63:0]            out_value;
  logic [15:0]            out_phase;
  logic [63:0]            out_start;
  logic [63:0]            out_end;
  logic [SLOTS-1:0][63:0] out_counts;
  logic                   out_full;

  logic                   starting;
  logic                   sep0;
  logic                   closing;
  logic                   table_is_full;
  logic                   slot_free;
  logic                   emit;

  assign pop_ready     = (state == S_IDLE);
  assign starting      = pop_data.sep_seen && (pop_data.sep_value != '0);
  assign sep0          = pop_data.sep_seen && (pop_data.sep_value == '0);
  assign closing       = pop_data.phase_seen || sep0;
  assign table_is_full = (seen_count >= CW'(TABLE_DEPTH));
  assign slot_free     = !out_valid || res.ready;
  assign emit          = (state == S_EMIT) && slot_free;

  always_ff @(posedge clk) begin
    if (emit && !table_is_full) begin
      seen_mem[seen_count[AW-1:0]] <= {open_value, open_phase};
    end
    rd_data <= seen_mem[idx[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      region_open <= 1'b0;
      open_value  <= '0;
      open_phase  <= '0;
      open_start  <= '0;
      sums        <= '0;
      seen_count  <= '0;
      idx         <= '0;
      cl_sep0     <= 1'b0;
      cl_ts       <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (pop_valid) begin
            cl_sep0 <= sep0;
            cl_ts   <= pop_data.ts;
            idx     <= '0;
            if (starting) begin
              region_open <= 1'b1;
              open_value  <= pop_data.sep_value;
              open_phase  <= '0;
              open_start  <= pop_data.ts;
              sums        <= '0;
            end else if (region_open) begin
              for (int i = 0; i < SLOTS; i++) begin
                sums[i] <= sums[i] + pop_data.deltas[i];
              end
            end
            if (closing && (starting || region_open)) begin
              state <= S_SEARCH;
            end
          end
        end
        S_SEARCH: begin
          state <= (idx < seen_count) ? S_CMP : S_EMIT;
        end
        S_CMP: begin
          if (rd_data == {open_value, open_phase}) begin
            state <= S_FIN;
          end else begin
            idx   <= idx + 1'b1;
            state <= S_SEARCH;
          end
        end
        S_EMIT: begin
          if (slot_free) begin
            if (!table_is_full) begin
              seen_count <= seen_count + 1'b1;
            end
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (cl_sep0) begin
            region_open <= 1'b0;
          end else begin
            if (open_phase != PHASE_MAX) begin
              open_phase <= open_phase + 1'b1;
            end
            open_start <= cl_ts;
            sums       <= '0;
          end
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_value  <= open_value;
      out_phase  <= open_phase;
      out_start  <= open_start;
      out_end    <= cl_ts;
      out_counts <= sums;
      out_full   <= table_is_full;
    end
  end

  assign res.valid        = out_valid;
  assign res.region_value = out_value;
  assign res.region_phase = out_phase;
  assign res.start_time   = out_start;
  assign res.end_time     = out_end;
  assign res.count_0      = out_counts[0];
  assign res.count_1      = out_counts[1];
  assign res.count_2      = out_counts[2];
  assign res.count_3      = out_counts[3];
  assign res.table_full   = out_full;

  `TRC_ASSERT(a_count_bound, clk, rst, seen_count <= CW'(TABLE_DEPTH), "seen count overflow")
  `TRC_ASSERT(a_idx_bound, clk, rst, (state == S_CMP) |-> (idx < seen_count), "search past fill")
  `TRC_ASSERT(a_emit_hold, clk, rst, (state == S_EMIT && out_valid && !res.ready) |=> (state == S_EMIT), "emit dropped while stalled")
  `TRC_ASSERT(a_pop_idle, clk, rst, (pop_valid && pop_ready) |-> (state == S_IDLE), "pop outside idle")

endmodule
